// ===== rtl/c128d_pkg.sv =====
// shared types, symbol codes and helper functions for the code 128 decoder
`timescale 1ns / 1ps

package c128d_pkg;

	// symbol values with a fixed meaning
	localparam logic [6:0] SYM_FNC3    = 7'd96;
	localparam logic [6:0] SYM_FNC2    = 7'd97;
	localparam logic [6:0] SYM_SHIFT   = 7'd98;
	localparam logic [6:0] SYM_CODE_C  = 7'd99;
	localparam logic [6:0] SYM_CODE_B  = 7'd100;
	localparam logic [6:0] SYM_CODE_A  = 7'd101;
	localparam logic [6:0] SYM_FNC1    = 7'd102;
	localparam logic [6:0] SYM_START_A = 7'd103;
	localparam logic [6:0] SYM_START_C = 7'd105;
	localparam logic [6:0] SYM_STOP    = 7'd106;
	localparam logic [6:0] SYM_HIGH_A  = 7'd64;

	// checksum modulus
	localparam logic [6:0] CHECK_MOD   = 7'd103;

	// code sets
	localparam logic [1:0] SET_A = 2'd0;
	localparam logic [1:0] SET_B = 2'd1;
	localparam logic [1:0] SET_C = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_TEXT    = 2'd0;
	localparam logic [1:0] KIND_END_OK  = 2'd1;
	localparam logic [1:0] KIND_END_BAD = 2'd2;
	localparam logic [1:0] KIND_REJECT  = 2'd3;

	// symbology modifiers
	localparam logic [1:0] MOD_PLAIN = 2'd0;
	localparam logic [1:0] MOD_GS1   = 2'd1;
	localparam logic [1:0] MOD_AIM   = 2'd2;

	// text bytes and offsets
	localparam logic [7:0] BYTE_GS      = 8'd29;
	localparam logic [7:0] BYTE_ZERO    = 8'h30;
	localparam logic [7:0] OFS_PLAIN    = 8'd32;
	localparam logic [7:0] OFS_HIGH     = 8'd160;
	localparam logic [7:0] OFS_CTRL     = 8'd64;

	// decoder state between items
	typedef struct packed {
		logic       active;
		logic [1:0] code_set;
		logic       shift_pending;
		logic       fnc4_latched;
		logic       fnc4_once;
		logic       init_seen;
		logic [1:0] ident_mode;
		logic [1:0] text_length;
		logic       lead0_digit;
		logic       lead0_letter;
		logic       lead1_digit;
		logic [1:0] held_count;
		logic [6:0] held_symbol;
		logic [6:0] position_mod;
		logic [6:0] check_sum;
		logic [1:0] data_count;
	} state_t;

	// one result item
	typedef struct packed {
		logic [1:0] kind;
		logic [1:0] char_count;
		logic [7:0] first_char;
		logic [7:0] second_char;
		logic [1:0] modifier;
		logic       reader_init;
	} res_t;

	// swap between sets a and b, anything else goes to a
	function automatic logic [1:0] toggle_ab(input logic [1:0] s);
		return (s == SET_A) ? SET_B : SET_A;
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= 8'h30) && (b <= 8'h39);
	endfunction

	function automatic logic is_letter(input logic [7:0] b);
		return ((b >= 8'h41) && (b <= 8'h5a)) || ((b >= 8'h61) && (b <= 8'h7a));
	endfunction

	// tens digit of a value below 100, by reciprocal multiply
	function automatic logic [3:0] tens_of(input logic [6:0] code);
		logic [14:0] p;
		p = 15'(code) * 15'd205;
		return p[14:11];
	endfunction

	// x mod 103 by folding: 128 is 25 mod 103
	function automatic logic [6:0] mod103(input logic [13:0] x);
		logic [11:0] a;
		logic [9:0]  b;
		logic [8:0]  c;
		a = (12'(x[13:7]) << 4) + (12'(x[13:7]) << 3) + 12'(x[13:7]) + 12'(x[6:0]);
		b = (10'(a[11:7]) << 4) + (10'(a[11:7]) << 3) + 10'(a[11:7]) + 10'(a[6:0]);
		c = (9'(b[9:7]) << 4) + (9'(b[9:7]) << 3) + 9'(b[9:7]) + 9'(b[6:0]);
		if (c >= 9'd206) begin
			c = c - 9'd206;
		end else if (c >= 9'd103) begin
			c = c - 9'd103;
		end
		return c[6:0];
	endfunction

endpackage

// ===== rtl/c128d_step.sv =====
// next-state and result logic for one code 128 symbol
`timescale 1ns / 1ps

module c128d_step (
	input  c128d_pkg::state_t st,
	input  logic [7:0]        held0,
	input  logic [7:0]        held1,
	input  logic [6:0]        symbol,
	output c128d_pkg::state_t st_d,
	output logic [7:0]        held0_d,
	output logic [7:0]        held1_d,
	output logic              emit,
	output c128d_pkg::res_t   res
);

	// digit split for code set c
	logic [3:0] tens;
	logic [3:0] ones;
	logic [6:0] ones_full;
	logic [13:0] weighted;

	assign tens      = c128d_pkg::tens_of(symbol);
	assign ones_full = symbol - 7'(tens) * 7'd10;
	assign ones      = ones_full[3:0];

	// running checksum term for the previous body symbol
	assign weighted = 14'(st.position_mod) * 14'(st.held_symbol) + 14'(st.check_sum);

	// decode one symbol
	always_comb begin
		c128d_pkg::state_t n;
		logic [1:0] nb;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [1:0] cur;
		logic       fnc1;
		logic       fnc1_c;
		logic       reject;
		logic       plain;
		logic [2:0] tl_sum;
		logic [7:0] v;

		n      = st;
		nb     = 2'd0;
		b0     = 8'd0;
		b1     = 8'd0;
		fnc1   = 1'b0;
		fnc1_c = 1'b0;
		reject = 1'b0;
		cur    = (st.code_set == c128d_pkg::SET_B) ? c128d_pkg::SET_B : c128d_pkg::SET_A;
		plain  = (st.fnc4_latched == st.fnc4_once);
		tl_sum = 3'd0;
		v      = 8'd0;
		emit   = 1'b0;
		res    = '0;
		held0_d = held0;
		held1_d = held1;

		if (!st.active) begin
			// idle: only a start code matters
			if (symbol >= c128d_pkg::SYM_START_A && symbol <= c128d_pkg::SYM_START_C) begin
				n              = '0;
				n.active       = 1'b1;
				n.code_set     = 2'(symbol - c128d_pkg::SYM_START_A);
				n.check_sum    = 7'(symbol - c128d_pkg::SYM_START_A);
				n.position_mod = 7'd1;
			end
		end else if (symbol == c128d_pkg::SYM_STOP) begin
			// stop: verify checksum
			emit = 1'b1;
			if (st.data_count < 2'd2) begin
				res.kind = c128d_pkg::KIND_REJECT;
			end else begin
				res.kind        = (st.check_sum == st.held_symbol) ?
					c128d_pkg::KIND_END_OK : c128d_pkg::KIND_END_BAD;
				res.modifier    = st.ident_mode;
				res.reader_init = st.init_seen;
			end
			n = '0;
		end else if (symbol >= c128d_pkg::SYM_START_A) begin
			// start code or out-of-range value inside a symbol
			emit     = 1'b1;
			res.kind = c128d_pkg::KIND_REJECT;
			n        = '0;
		end else begin
			if (st.code_set == c128d_pkg::SET_C) begin
				// code set c: digit pairs 00 to 99
				if (symbol < c128d_pkg::SYM_CODE_B) begin
					nb = 2'd2;
					b0 = c128d_pkg::BYTE_ZERO + 8'(tens);
					b1 = c128d_pkg::BYTE_ZERO + 8'(ones);
				end else if (symbol == c128d_pkg::SYM_FNC1) begin
					fnc1   = 1'b1;
					fnc1_c = 1'b1;
				end else begin
					n.code_set = (symbol == c128d_pkg::SYM_CODE_A) ?
						c128d_pkg::SET_A : c128d_pkg::SET_B;
				end
			end else begin
				// code sets a and b
				if (symbol == c128d_pkg::SYM_FNC1) begin
					fnc1 = 1'b1;
				end else if (symbol == c128d_pkg::SYM_FNC2) begin
					n.init_seen = st.init_seen;
				end else if (symbol == c128d_pkg::SYM_FNC3) begin
					n.init_seen = 1'b1;
				end else if (symbol == c128d_pkg::SYM_SHIFT) begin
					if (st.shift_pending) begin
						reject = 1'b1;
					end
					n.shift_pending = 1'b1;
					n.code_set      = c128d_pkg::toggle_ab(cur);
				end else if (symbol == c128d_pkg::SYM_CODE_A || symbol == c128d_pkg::SYM_CODE_B) begin
					// switch set, or fnc4 when already in that set
					if ((symbol == c128d_pkg::SYM_CODE_A) == (cur == c128d_pkg::SET_A)) begin
						if (st.fnc4_once) begin
							n.fnc4_latched = ~st.fnc4_latched;
						end
						n.fnc4_once = ~st.fnc4_once;
					end else begin
						n.code_set = (symbol == c128d_pkg::SYM_CODE_A) ?
							c128d_pkg::SET_A : c128d_pkg::SET_B;
					end
				end else if (symbol == c128d_pkg::SYM_CODE_C) begin
					n.code_set = c128d_pkg::SET_C;
				end else begin
					// plain text character
					if (cur == c128d_pkg::SET_A && symbol >= c128d_pkg::SYM_HIGH_A) begin
						v = plain ? 8'(symbol) - c128d_pkg::OFS_CTRL : 8'(symbol) + c128d_pkg::OFS_CTRL;
					end else begin
						v = plain ? 8'(symbol) + c128d_pkg::OFS_PLAIN : 8'(symbol) + c128d_pkg::OFS_HIGH;
					end
					nb          = 2'd1;
					b0          = v;
					n.fnc4_once = 1'b0;
				end
				// a shift applies to one symbol only
				if (st.shift_pending) begin
					n.code_set      = c128d_pkg::toggle_ab(n.code_set);
					n.shift_pending = 1'b0;
				end
			end

			// fnc1: gs1 at front, aim after one letter or two digits, else a gs byte
			if (fnc1) begin
				if (st.text_length == 2'd0) begin
					n.ident_mode = c128d_pkg::MOD_GS1;
				end else if ((fnc1_c && st.text_length == 2'd2 && st.lead0_digit && st.lead1_digit)
						|| (!fnc1_c && st.text_length == 2'd1 && st.lead0_letter)) begin
					n.ident_mode = c128d_pkg::MOD_AIM;
				end else begin
					nb = 2'd1;
					b0 = c128d_pkg::BYTE_GS;
				end
			end

			// remember the class of the first two text bytes
			if (nb != 2'd0 && st.text_length == 2'd0) begin
				n.lead0_digit  = c128d_pkg::is_digit(b0);
				n.lead0_letter = c128d_pkg::is_letter(b0);
			end
			if (nb != 2'd0 && st.text_length == 2'd1) begin
				n.lead1_digit = c128d_pkg::is_digit(b0);
			end
			if (nb == 2'd2 && st.text_length == 2'd0) begin
				n.lead1_digit = c128d_pkg::is_digit(b1);
			end
			tl_sum        = 3'(st.text_length) + 3'(nb);
			n.text_length = (tl_sum > 3'd3) ? 2'd3 : tl_sum[1:0];

			if (reject) begin
				emit     = 1'b1;
				res.kind = c128d_pkg::KIND_REJECT;
				n        = '0;
			end else begin
				// checksum over body symbols, check symbol excluded by the one-symbol lag
				if (st.data_count != 2'd0) begin
					n.check_sum    = c128d_pkg::mod103(weighted);
					n.position_mod = (st.position_mod == c128d_pkg::CHECK_MOD - 7'd1) ?
						7'd0 : st.position_mod + 7'd1;
				end
				n.held_symbol = symbol;
				n.data_count  = (st.data_count == 2'd2) ? 2'd2 : st.data_count + 2'd1;

				// release the text held from the previous symbol
				if (st.held_count != 2'd0) begin
					emit            = 1'b1;
					res.kind        = c128d_pkg::KIND_TEXT;
					res.char_count  = st.held_count;
					res.first_char  = held0;
					res.second_char = (st.held_count > 2'd1) ? held1 : 8'd0;
				end
				n.held_count = nb;
				held0_d      = b0;
				held1_d      = b1;
			end
		end

		st_d = n;
	end

endmodule

// ===== rtl/code128_symbol_to_text_decoder.sv =====
// top level of the code 128 symbol-to-text decoder
`timescale 1ns / 1ps

// Decodes a stream of Code 128 symbol values (0-106) into text bytes. A start
// code opens a symbol; each later body symbol releases the text of the one
// before it, so the check symbol's text never appears. The stop code gives an
// end item with checksum status, symbology modifier and reader-init flag, or a
// reject item. One symbol is taken every clock while in_ready is high: all
// decode, including the mod-103 multiply-add of the checksum, sits between
// the state register and the result register, which is loaded when its
// symbol is taken. A waiting result holds while out_ready is low; a new
// symbol is taken when out_ready is high or no result is waiting.

module code128_symbol_to_text_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [6:0] symbol,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] kind,
	output logic [1:0] char_count,
	output logic [7:0] first_char,
	output logic [7:0] second_char,
	output logic [1:0] modifier,
	output logic       reader_init
);

	c128d_pkg::state_t st_q;
	c128d_pkg::state_t st_d;
	c128d_pkg::res_t   res_d;
	c128d_pkg::res_t   res_q;
	logic [7:0]        held0_q;
	logic [7:0]        held1_q;
	logic [7:0]        held0_d;
	logic [7:0]        held1_d;
	logic              emit;
	logic              out_valid_q;
	logic              accept;

	// handshake
	assign accept   = in_valid && in_ready;
	assign in_ready = !out_valid_q || out_ready;

	// per-symbol decode
	c128d_step u_step (
		.st      (st_q),
		.held0   (held0_q),
		.held1   (held1_q),
		.symbol  (symbol),
		.st_d    (st_d),
		.held0_d (held0_d),
		.held1_d (held1_d),
		.emit    (emit),
		.res     (res_d)
	);

	// decoder state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				st_q        <= st_d;
				out_valid_q <= emit;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// held text bytes and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			held0_q <= held0_d;
			held1_q <= held1_d;
		end
		if (accept && emit) begin
			res_q <= res_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = res_q.kind;
	assign char_count  = res_q.char_count;
	assign first_char  = res_q.first_char;
	assign second_char = res_q.second_char;
	assign modifier    = res_q.modifier;
	assign reader_init = res_q.reader_init;

	// an end or reject item carries no text
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.kind != c128d_pkg::KIND_TEXT |-> res_q.char_count == 2'd0)
		else $error("end item carries text");

	// a text item carries one or two bytes
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.kind == c128d_pkg::KIND_TEXT |->
			(res_q.char_count == 2'd1 || res_q.char_count == 2'd2))
		else $error("text item with bad byte count");

	// an idle decoder never produces an item
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && !st_q.active |=> !out_valid_q)
		else $error("item produced while idle");

	// an end or reject leaves the decoder idle
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && emit && res_d.kind != c128d_pkg::KIND_TEXT |=> !st_q.active)
		else $error("still active after end of symbol");

	// checksum and weight stay reduced
	assert property (@(posedge clk) disable iff (!arst_n)
		st_q.check_sum < c128d_pkg::CHECK_MOD && st_q.position_mod < c128d_pkg::CHECK_MOD)
		else $error("checksum state out of range");

endmodule

// ===== dv/code128_symbol_to_text_decoder_test.sv =====
// self-checking testbench for the code 128 symbol-to-text decoder
`timescale 1ns / 1ps

module code128_symbol_to_text_decoder_test;

	localparam int CLK_PERIOD  = 8;
	localparam int ITEM_GOAL   = 1950;
	localparam int STALL_LIMIT = 4000;
	localparam int MAX_REPORTS = 10;
	localparam int DRAIN_WAIT  = 8;

	localparam logic [6:0] SYM_START_B = c128d_pkg::SYM_START_A + 7'd1;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [6:0] symbol = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [1:0] kind;
	logic [1:0] char_count;
	logic [7:0] first_char;
	logic [7:0] second_char;
	logic [1:0] modifier;
	logic       reader_init;

	code128_symbol_to_text_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.symbol(symbol),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.char_count(char_count),
		.first_char(first_char),
		.second_char(second_char),
		.modifier(modifier),
		.reader_init(reader_init)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// symbols waiting to be sent and results the decoder owes us
	logic [6:0]        symbol_queue[$];
	c128d_pkg::res_t   decoder_results_due[$];
	int         fed_count = 0;
	int         total_items = 1;
	int         fail_count = 0;
	int         quiet_cycles = 0;

	// running checksum of the symbol under construction
	int run_sum;
	int run_pos;

	// decoder shadow state
	logic       dec_active;
	logic [1:0] dec_set;
	logic       dec_shift;
	logic       dec_f4_latch;
	logic       dec_f4_once;
	logic       dec_init;
	logic [1:0] dec_ident;
	logic [1:0] dec_text_len;
	logic [1:0] dec_held_n;
	logic [1:0] dec_new_n;
	logic [1:0] dec_data_n;
	logic [6:0] dec_held_sym;
	logic [6:0] dec_pos;
	logic [6:0] dec_sum;
	logic [7:0] dec_lead[2];
	logic [7:0] dec_held[2];
	logic [7:0] dec_new[2];

	// append to the tail of the pending queues
	task automatic queue_symbol(input logic [6:0] v);
		symbol_queue = {symbol_queue, v};
	endtask

	task automatic queue_result(input c128d_pkg::res_t r);
		decoder_results_due = {decoder_results_due, r};
	endtask

	task automatic clear_decoder();
		dec_active   = 1'b0;
		dec_set      = c128d_pkg::SET_A;
		dec_shift    = 1'b0;
		dec_f4_latch = 1'b0;
		dec_f4_once  = 1'b0;
		dec_init     = 1'b0;
		dec_ident    = c128d_pkg::MOD_PLAIN;
		dec_text_len = '0;
		dec_held_n   = '0;
		dec_new_n    = '0;
		dec_data_n   = '0;
		dec_held_sym = '0;
		dec_pos      = '0;
		dec_sum      = '0;
		dec_lead[0]  = '0;
		dec_lead[1]  = '0;
		dec_held[0]  = '0;
		dec_held[1]  = '0;
		dec_new[0]   = '0;
		dec_new[1]   = '0;
	endtask

	function automatic logic ascii_digit(input logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic logic ascii_letter(input logic [7:0] b);
		return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
	endfunction

	// one text byte from the current symbol; the first two are kept for the aim test
	task automatic push_text(input logic [7:0] b);
		if (dec_new_n < 2'd2) begin
			dec_new[dec_new_n[0]] = b;
			dec_new_n = dec_new_n + 2'd1;
		end
		if (dec_text_len < 2'd2) begin
			dec_lead[dec_text_len[0]] = b;
		end
		if (dec_text_len < 2'd3) begin
			dec_text_len = dec_text_len + 2'd1;
		end
	endtask

	// fnc1 first gives gs1, after one letter or two digits gives aim, else a gs byte
	task automatic apply_fnc1(input logic in_c);
		if (dec_text_len == 2'd0) begin
			dec_ident = c128d_pkg::MOD_GS1;
		end else if ((in_c && dec_text_len == 2'd2 && ascii_digit(dec_lead[0])
				&& ascii_digit(dec_lead[1]))
				|| (!in_c && dec_text_len == 2'd1 && ascii_letter(dec_lead[0]))) begin
			dec_ident = c128d_pkg::MOD_AIM;
		end else begin
			push_text(c128d_pkg::BYTE_GS);
		end
	endtask

	// decode one body symbol into text and mode changes; ok low on a double shift
	task automatic decode_body(input logic [6:0] code, output logic ok);
		logic       unshift;
		logic [1:0] cur;
		logic [1:0] target;
		logic       plain;
		logic [7:0] v;
		ok = 1'b1;
		if (dec_set == c128d_pkg::SET_C) begin
			if (code < c128d_pkg::SYM_CODE_B) begin
				push_text(c128d_pkg::BYTE_ZERO + 8'(code / 7'd10));
				push_text(c128d_pkg::BYTE_ZERO + 8'(code % 7'd10));
			end else if (code == c128d_pkg::SYM_FNC1) begin
				apply_fnc1(1'b1);
			end else begin
				dec_set = (code == c128d_pkg::SYM_CODE_A) ? c128d_pkg::SET_A : c128d_pkg::SET_B;
			end
			return;
		end
		unshift = dec_shift;
		cur = (dec_set == c128d_pkg::SET_B) ? c128d_pkg::SET_B : c128d_pkg::SET_A;
		case (code)
			c128d_pkg::SYM_FNC1: begin
				apply_fnc1(1'b0);
			end
			c128d_pkg::SYM_FNC2: begin
				// no effect on the text
			end
			c128d_pkg::SYM_FNC3: begin
				dec_init = 1'b1;
			end
			c128d_pkg::SYM_SHIFT: begin
				if (dec_shift) begin
					ok = 1'b0;
					return;
				end
				dec_shift = 1'b1;
				dec_set = (cur == c128d_pkg::SET_A) ? c128d_pkg::SET_B : c128d_pkg::SET_A;
			end
			c128d_pkg::SYM_CODE_A, c128d_pkg::SYM_CODE_B: begin
				target = (code == c128d_pkg::SYM_CODE_A) ? c128d_pkg::SET_A : c128d_pkg::SET_B;
				// code of the current set is fnc4: twice in a row toggles the latch
				if (cur == target) begin
					if (dec_f4_once) begin
						dec_f4_latch = ~dec_f4_latch;
					end
					dec_f4_once = ~dec_f4_once;
				end else begin
					dec_set = target;
				end
			end
			c128d_pkg::SYM_CODE_C: begin
				dec_set = c128d_pkg::SET_C;
			end
			default: begin
				plain = dec_f4_latch == dec_f4_once;
				if (cur == c128d_pkg::SET_A && code >= c128d_pkg::SYM_HIGH_A) begin
					v = plain ? 8'(code) - c128d_pkg::OFS_CTRL : 8'(code) + c128d_pkg::OFS_CTRL;
				end else begin
					v = plain ? 8'(code) + c128d_pkg::OFS_PLAIN : 8'(code) + c128d_pkg::OFS_HIGH;
				end
				push_text(v);
				dec_f4_once = 1'b0;
			end
		endcase
		if (unshift) begin
			dec_set = (dec_set == c128d_pkg::SET_A) ? c128d_pkg::SET_B : c128d_pkg::SET_A;
			dec_shift = 1'b0;
		end
	endtask

	// advance the shadow decoder by one accepted symbol and queue what it releases
	task automatic decode_symbol(input logic [6:0] s);
		logic ok;
		c128d_pkg::res_t r;
		r = '0;
		if (!dec_active) begin
			if (s >= c128d_pkg::SYM_START_A && s <= c128d_pkg::SYM_START_C) begin
				clear_decoder();
				dec_active = 1'b1;
				dec_set = 2'(s - c128d_pkg::SYM_START_A);
				dec_sum = s - c128d_pkg::SYM_START_A;
				dec_pos = 7'd1;
			end
		end else if (s == c128d_pkg::SYM_STOP) begin
			if (dec_data_n < 2'd2) begin
				r.kind = c128d_pkg::KIND_REJECT;
			end else begin
				r.kind = (dec_sum == dec_held_sym) ?
					c128d_pkg::KIND_END_OK : c128d_pkg::KIND_END_BAD;
				r.modifier = dec_ident;
				r.reader_init = dec_init;
			end
			queue_result(r);
			clear_decoder();
		end else if (s >= c128d_pkg::SYM_START_A) begin
			r.kind = c128d_pkg::KIND_REJECT;
			queue_result(r);
			clear_decoder();
		end else begin
			dec_new_n = '0;
			dec_new[0] = '0;
			dec_new[1] = '0;
			decode_body(s, ok);
			if (!ok) begin
				r.kind = c128d_pkg::KIND_REJECT;
				queue_result(r);
				clear_decoder();
			end else begin
				// weighted sum over the body, the newest symbol held back as the check
				if (dec_data_n >= 2'd1) begin
					dec_sum = 7'((int'(dec_sum) + int'(dec_pos) * int'(dec_held_sym))
						% int'(c128d_pkg::CHECK_MOD));
					dec_pos = 7'((int'(dec_pos) + 1) % int'(c128d_pkg::CHECK_MOD));
				end
				dec_held_sym = s;
				if (dec_data_n < 2'd2) begin
					dec_data_n = dec_data_n + 2'd1;
				end
				if (dec_held_n > 2'd0) begin
					r.kind = c128d_pkg::KIND_TEXT;
					r.char_count = dec_held_n;
					r.first_char = dec_held[0];
					r.second_char = (dec_held_n > 2'd1) ? dec_held[1] : 8'd0;
					queue_result(r);
				end
				dec_held_n = dec_new_n;
				dec_held[0] = dec_new[0];
				dec_held[1] = dec_new[1];
			end
		end
	endtask

	// symbol construction with a running checksum
	task automatic open_symbol(input logic [6:0] start);
		queue_symbol(start);
		run_sum = int'(start - c128d_pkg::SYM_START_A);
		run_pos = 1;
	endtask

	task automatic add_body(input logic [6:0] v);
		queue_symbol(v);
		run_sum = (run_sum + (run_pos % int'(c128d_pkg::CHECK_MOD)) * int'(v))
			% int'(c128d_pkg::CHECK_MOD);
		run_pos++;
	endtask

	task automatic close_symbol(input logic good);
		int check;
		check = good ? run_sum
			: (run_sum + int'($urandom_range(1, 102))) % int'(c128d_pkg::CHECK_MOD);
		queue_symbol(7'(check));
		queue_symbol(c128d_pkg::SYM_STOP);
	endtask

	function automatic logic [6:0] random_body();
		if ($urandom_range(4) == 0) begin
			return 7'($urandom_range(c128d_pkg::SYM_FNC3, c128d_pkg::SYM_FNC1));
		end
		return 7'($urandom_range(95));
	endfunction

	// idling per phase: none, sender gaps, receiver stalls, both light
	function automatic int phase_now();
		return fed_count * 4 / total_items;
	endfunction

	function automatic logic sender_gap();
		case (phase_now())
			1: return $urandom_range(99) < 84;
			3: return $urandom_range(99) < 20;
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic receiver_stall();
		case (phase_now())
			2: return $urandom_range(99) < 84;
			3: return $urandom_range(99) < 20;
			default: return 1'b0;
		endcase
	endfunction

	// symbol driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			symbol <= '0;
		end else begin
			if (in_valid && in_ready) begin
				decode_symbol(symbol);
				fed_count <= fed_count + 1;
			end
			if (!in_valid || in_ready) begin
				if (symbol_queue.size() > 0 && !sender_gap()) begin
					in_valid <= 1'b1;
					symbol <= symbol_queue.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and checker
	always @(posedge clk or negedge arst_n) begin : result_check
		c128d_pkg::res_t got;
		c128d_pkg::res_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				got = {kind, char_count, first_char, second_char, modifier, reader_init};
				if (decoder_results_due.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS) begin
						$display("%0t: result with none expected: kind %0d count %0d",
							$realtime, got.kind, got.char_count);
					end
				end else begin
					want = decoder_results_due.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= MAX_REPORTS) begin
							$display("%0t: mismatch exp kind %0d cnt %0d c0 %0d c1 %0d mod %0d ri %0d",
								$realtime, want.kind, want.char_count, want.first_char,
								want.second_char, want.modifier, want.reader_init);
							$display("%0t:          got kind %0d cnt %0d c0 %0d c1 %0d mod %0d ri %0d",
								$realtime, got.kind, got.char_count, got.first_char,
								got.second_char, got.modifier, got.reader_init);
						end
					end
				end
			end
			out_ready <= !receiver_stall();
		end
	end

	// watchdog on cycles with no item moving
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		int pick;
		int len;
		clear_decoder();

		// directed: junk while idle
		queue_symbol(7'd127);
		queue_symbol(7'd0);
		// set c: gs1 lead, digit extremes, late fnc1 as gs byte, switch to a, control byte
		open_symbol(c128d_pkg::SYM_START_C);
		add_body(c128d_pkg::SYM_FNC1);
		add_body(7'd0);
		add_body(7'd99);
		add_body(c128d_pkg::SYM_FNC1);
		add_body(c128d_pkg::SYM_CODE_A);
		add_body(c128d_pkg::SYM_HIGH_A);
		close_symbol(1'b1);
		// set b: aim after a letter, fnc3, fnc2, shift, fnc4 single, bad checksum
		open_symbol(SYM_START_B);
		add_body(7'd65);
		add_body(c128d_pkg::SYM_FNC1);
		add_body(c128d_pkg::SYM_FNC3);
		add_body(c128d_pkg::SYM_FNC2);
		add_body(c128d_pkg::SYM_SHIFT);
		add_body(7'd95);
		add_body(c128d_pkg::SYM_CODE_A);
		add_body(c128d_pkg::SYM_CODE_A);
		add_body(7'd0);
		close_symbol(1'b0);
		// two shifts in a row
		open_symbol(c128d_pkg::SYM_START_A);
		queue_symbol(c128d_pkg::SYM_SHIFT);
		queue_symbol(c128d_pkg::SYM_SHIFT);
		queue_symbol(c128d_pkg::SYM_STOP);
		// stop right after start
		open_symbol(c128d_pkg::SYM_START_C);
		queue_symbol(c128d_pkg::SYM_STOP);
		// start code inside a body
		open_symbol(SYM_START_B);
		add_body(7'd5);
		queue_symbol(c128d_pkg::SYM_START_A);

		// random: mostly well-formed symbols, some broken ones and noise
		while (symbol_queue.size() < ITEM_GOAL) begin
			pick = $urandom_range(99);
			if (pick < 80) begin
				open_symbol(7'($urandom_range(c128d_pkg::SYM_START_A, c128d_pkg::SYM_START_C)));
				len = ($urandom_range(59) == 0) ? $urandom_range(100, 115) : $urandom_range(1, 10);
				repeat (len) add_body(random_body());
				close_symbol($urandom_range(9) != 0);
			end else if (pick < 92) begin
				open_symbol(7'($urandom_range(c128d_pkg::SYM_START_A, c128d_pkg::SYM_START_C)));
				len = $urandom_range(0, 4);
				repeat (len) add_body(random_body());
				case ($urandom_range(3))
					0: queue_symbol(7'($urandom_range(c128d_pkg::SYM_START_A,
						c128d_pkg::SYM_START_C)));
					1: queue_symbol(7'($urandom_range(c128d_pkg::SYM_STOP + 1, 127)));
					2: begin
						queue_symbol(c128d_pkg::SYM_SHIFT);
						queue_symbol(c128d_pkg::SYM_SHIFT);
					end
					default: begin
						// plain stop, too short when the body is under two symbols
					end
				endcase
				queue_symbol(c128d_pkg::SYM_STOP);
			end else begin
				repeat ($urandom_range(1, 4)) queue_symbol(7'($urandom_range(127)));
				queue_symbol(c128d_pkg::SYM_STOP);
			end
		end
		total_items = symbol_queue.size();

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (symbol_queue.size() > 0 || in_valid) begin
			@(posedge clk);
		end
		while (decoder_results_due.size() > 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_WAIT) @(posedge clk);

		if (fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/c128d_pkg.sv
rtl/c128d_step.sv
rtl/code128_symbol_to_text_decoder.sv
dv/code128_symbol_to_text_decoder_test.sv
